// File: rtl/core/ud3_pkg.sv
// Package for the unit direction block: widths, fixed-point setting and the
// per-word pipeline record. No dependencies.
`default_nettype none
package ud3_pkg;
   localparam int OUT_FRAC_BITS = 14;
   localparam int IN_W  = 24;
   localparam int OUT_W = 16;
   localparam int DW    = IN_W + 1;
   localparam int SQW   = 2 * DW;
   localparam int SW    = 2 * IN_W + 2;
   localparam int QW    = OUT_FRAC_BITS + 1;
   localparam int WW    = 2 * OUT_FRAC_BITS + SW + 2;
   localparam int BW    = $clog2(QW);
   localparam int NSTEP = QW;
   localparam int NPREP = 3;
   localparam int NSTG  = NPREP + NSTEP + 1;

   typedef struct packed {
      logic          neg;
      logic [QW-1:0] q;
      logic [WW-1:0] p;
      logic [WW-1:0] qs;
      logic [WW-1:0] r;
   } comp_type;

   typedef struct packed {
      comp_type [2:0] c;
      logic [SW-1:0]  s;
      logic           zero;
   } item_type;
endpackage
`default_nettype wire

// File: rtl/core/ud3_prep.sv
// Front stages: difference vector, squares, squared length and remainder set-up.
// Depends on ud3_pkg.
`default_nettype none
module ud3_prep
   import ud3_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [NPREP-1:0]       en,
   input  wire logic signed [IN_W-1:0] from_x,
   input  wire logic signed [IN_W-1:0] from_y,
   input  wire logic signed [IN_W-1:0] from_z,
   input  wire logic signed [IN_W-1:0] to_x,
   input  wire logic signed [IN_W-1:0] to_y,
   input  wire logic signed [IN_W-1:0] to_z,
   output item_type                    item
);
   logic [2:0][DW-1:0]  d_ff, d_in;
   logic [2:0]          neg_ff, neg_in;
   logic [2:0][SQW-1:0] sq_ff, sq_in;
   item_type            item_ff, item_in;
   logic [DW-1:0]       mag;
   logic [SW-1:0]       ssum;

   always_comb begin
      d_in[0] = {to_x[IN_W-1], to_x} - {from_x[IN_W-1], from_x};
      d_in[1] = {to_y[IN_W-1], to_y} - {from_y[IN_W-1], from_y};
      d_in[2] = {to_z[IN_W-1], to_z} - {from_z[IN_W-1], from_z};
   end

   always_comb begin
      mag = '0;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = d_ff[i][DW-1];
         mag       = neg_in[i] ? (~d_ff[i] + DW'(1)) : d_ff[i];
         sq_in[i]  = SQW'(mag) * SQW'(mag);
      end
   end

   always_comb begin
      ssum = SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      item_in.s    = ssum;
      item_in.zero = (ssum == '0);
      for (int i = 0; i < 3; i++) begin
         item_in.c[i].neg = neg_ff[i];
         item_in.c[i].q   = '0;
         item_in.c[i].p   = '0;
         item_in.c[i].qs  = '0;
         item_in.c[i].r   = WW'(sq_ff[i]) << (2 * OUT_FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d_ff <= d_in;
      end
      if (en[1]) begin
         neg_ff <= neg_in;
         sq_ff  <= sq_in;
      end
      if (en[2]) begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;
endmodule
`default_nettype wire

// File: rtl/core/ud3_step.sv
// One quotient bit per component: trial q^2*S built by shift and add, kept if
// it stays within the scaled squared component. Depends on ud3_pkg.
`default_nettype none
module ud3_step
   import ud3_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [BW-1:0] bit_idx,
   input  wire item_type      item_i,
   output item_type           item_o
);
   item_type      item_ff, item_in;
   logic [WW-1:0] trial;
   logic [WW-1:0] s_w;

   always_comb begin
      item_in = item_i;
      s_w     = WW'(item_i.s);
      trial   = '0;
      for (int i = 0; i < 3; i++) begin
         trial = item_i.c[i].p + (item_i.c[i].qs << (bit_idx + BW'(1)))
               + (s_w << (2 * bit_idx));
         if (trial <= item_i.c[i].r) begin
            item_in.c[i].q  = item_i.c[i].q | (QW'(1) << bit_idx);
            item_in.c[i].p  = trial;
            item_in.c[i].qs = item_i.c[i].qs + (s_w << bit_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign item_o = item_ff;
endmodule
`default_nettype wire

// File: rtl/core/unit_direction_3d.sv
// Unit direction between two 3D points: front stages, one stage per quotient
// bit, saturating output register. Depends on ud3_pkg, ud3_prep, ud3_step.
// A result passes through the front stages, the quotient-bit stages and the output register in turn.
// Throughput: one word per cycle while rsp_stall is low; each stage holds only while its successor is full and held.
// Reset clears every stage valid bit; payload registers are not reset.
`default_nettype none
module unit_direction_3d
   import ud3_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic signed [IN_W-1:0]  req_from_x,
   input  wire logic signed [IN_W-1:0]  req_from_y,
   input  wire logic signed [IN_W-1:0]  req_from_z,
   input  wire logic signed [IN_W-1:0]  req_to_x,
   input  wire logic signed [IN_W-1:0]  req_to_y,
   input  wire logic signed [IN_W-1:0]  req_to_z,
   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic signed [OUT_W-1:0] rsp_unit_x,
   output      logic signed [OUT_W-1:0] rsp_unit_y,
   output      logic signed [OUT_W-1:0] rsp_unit_z,
   output      logic                    rsp_zero_length
);
   logic [NSTG-1:0]       v_ff, v_in, adv;
   item_type [NSTEP:0]    chain;
   logic [2:0][OUT_W-1:0] u_ff, u_in;
   logic                  z_ff, z_in;
   logic [31:0]           qx;

   always_comb begin
      adv[NSTG-1] = !v_ff[NSTG-1] || !rsp_stall;
      for (int k = NSTG - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = adv[0] ? req_valid : v_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         if (adv[k]) begin
            v_in[k] = v_ff[k-1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   ud3_prep u_prep (
      .clock  (clock),
      .en     (adv[NPREP-1:0]),
      .from_x (req_from_x),
      .from_y (req_from_y),
      .from_z (req_from_z),
      .to_x   (req_to_x),
      .to_y   (req_to_y),
      .to_z   (req_to_z),
      .item   (chain[0])
   );

   for (genvar g = 0; g < NSTEP; g++) begin : g_step
      ud3_step u_step (
         .clock   (clock),
         .en      (adv[NPREP+g]),
         .bit_idx (BW'(OUT_FRAC_BITS - g)),
         .item_i  (chain[g]),
         .item_o  (chain[g+1])
      );
   end

   always_comb begin
      z_in = chain[NSTEP].zero;
      qx   = '0;
      for (int i = 0; i < 3; i++) begin
         qx = 32'(chain[NSTEP].c[i].q);
         if (z_in) begin
            u_in[i] = '0;
         end else if (chain[NSTEP].c[i].neg) begin
            u_in[i] = (qx > 32'd32768) ? OUT_W'(16'h8000) : OUT_W'(~qx + 32'd1);
         end else begin
            u_in[i] = (qx > 32'd32767) ? OUT_W'(16'h7fff) : OUT_W'(qx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[NSTG-1]) begin
         u_ff <= u_in;
         z_ff <= z_in;
      end
   end

   assign req_stall       = !adv[0];
   assign rsp_valid       = v_ff[NSTG-1];
   assign rsp_unit_x      = u_ff[0];
   assign rsp_unit_y      = u_ff[1];
   assign rsp_unit_z      = u_ff[2];
   assign rsp_zero_length = z_ff;

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |-> rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0)
      else $error("zero length word carries non-zero direction");
   a_empty_tail: assert property (@(posedge clock) disable iff (reset)
      !v_ff[NSTG-1] |-> !req_stall)
      else $error("input held with empty output stage");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> v_ff[0])
      else $error("accepted word lost at entry");
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule
`default_nettype wire

// File: bench/unit_direction_3d_checker.sv
// Checker for unit_direction_3d: watches both channels, predicts each result
// from the accepted word and compares in order. Depends on ud3_pkg.
module unit_direction_3d_checker
   import ud3_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_stall,
   input  wire logic signed [IN_W-1:0]  req_from_x,
   input  wire logic signed [IN_W-1:0]  req_from_y,
   input  wire logic signed [IN_W-1:0]  req_from_z,
   input  wire logic signed [IN_W-1:0]  req_to_x,
   input  wire logic signed [IN_W-1:0]  req_to_y,
   input  wire logic signed [IN_W-1:0]  req_to_z,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire logic signed [OUT_W-1:0] rsp_unit_x,
   input  wire logic signed [OUT_W-1:0] rsp_unit_y,
   input  wire logic signed [OUT_W-1:0] rsp_unit_z,
   input  wire logic                    rsp_zero_length,
   output int                           fail_count,
   output int                           pending
);
   typedef struct packed {
      logic signed [OUT_W-1:0] ux;
      logic signed [OUT_W-1:0] uy;
      logic signed [OUT_W-1:0] uz;
      logic                    zero;
   } direction_type;

   direction_type due_mem [0:63];
   logic [5:0]    due_wr, due_rd;

   // largest q with q^2 * s <= mag^2 * 2^(2*frac), then saturate
   function automatic logic signed [OUT_W-1:0] unit_component(
      input logic signed [63:0] d, input logic [63:0] s);
      logic [255:0] rhs;
      logic [255:0] lhs;
      logic [63:0]  mag;
      logic [63:0]  q;
      logic [63:0]  t;
      mag = d < 0 ? -d : d;
      rhs = (256'(mag) * 256'(mag)) << (2 * OUT_FRAC_BITS);
      q = 0;
      for (int b = OUT_FRAC_BITS; b >= 0; b--) begin
         t = q | (64'd1 << b);
         lhs = 256'(t) * 256'(t) * 256'(s);
         if (lhs <= rhs) q = t;
      end
      if (d < 0) return (q > 32768) ? -16'sd32768 : -q[OUT_W-1:0];
      return (q > 32767) ? 16'sd32767 : q[OUT_W-1:0];
   endfunction

   function automatic direction_type predict_direction(
      input logic signed [63:0] dx, input logic signed [63:0] dy,
      input logic signed [63:0] dz);
      direction_type r;
      logic [63:0] s;
      s = dx * dx + dy * dy + dz * dz;
      if (s == 0) begin
         r = '0;
         r.zero = 1'b1;
      end else begin
         r.ux = unit_component(dx, s);
         r.uy = unit_component(dy, s);
         r.uz = unit_component(dz, s);
         r.zero = 1'b0;
      end
      return r;
   endfunction

   assign pending = int'(due_wr - due_rd);

   always @(posedge clock) begin
      direction_type e;
      if (reset) begin
         fail_count <= 0;
         due_wr     <= '0;
         due_rd     <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            due_mem[due_wr] <= predict_direction(
               64'(req_to_x) - 64'(req_from_x), 64'(req_to_y) - 64'(req_from_y),
               64'(req_to_z) - 64'(req_from_z));
            due_wr <= due_wr + 6'd1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_wr == due_rd) begin
               if (fail_count < 10) $display("unexpected word at %0t", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               e = due_mem[due_rd];
               due_rd <= due_rd + 6'd1;
               if (e.ux !== rsp_unit_x || e.uy !== rsp_unit_y || e.uz !== rsp_unit_z
                   || e.zero !== rsp_zero_length) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                        e.ux, e.uy, e.uz, e.zero, rsp_unit_x, rsp_unit_y, rsp_unit_z,
                        rsp_zero_length);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: bench/tb_unit_direction_3d.sv
// Top of the unit_direction_3d bench: clock, reset, point-pair stimulus with
// random gaps and stalls, verdict. Depends on ud3_pkg and the checker.
module tb_unit_direction_3d;
   import ud3_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic rsp_stall = 0;
   logic req_stall, rsp_valid, rsp_zero_length;
   logic signed [IN_W-1:0] req_from_x = 0, req_from_y = 0, req_from_z = 0;
   logic signed [IN_W-1:0] req_to_x = 0, req_to_y = 0, req_to_z = 0;
   logic signed [OUT_W-1:0] rsp_unit_x, rsp_unit_y, rsp_unit_z;
   int fail_count, pending, cycles = 0;
   logic quiet = 0;

   unit_direction_3d uut (.*);
   unit_direction_3d_checker chk (.*);

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver stalls in bursts
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 5);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   function automatic logic [IN_W-1:0] pick_coord(input logic [IN_W-1:0] base);
      case ($urandom_range(0, 5))
         0: return IN_W'({$urandom});
         1: return base + IN_W'($urandom_range(0, 8)) - IN_W'(4);
         2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         default: return base + IN_W'({$urandom} >> $urandom_range(8, 31));
      endcase
   endfunction

   task automatic send_pair(input logic [IN_W-1:0] fx, fy, fz, tx, ty, tz);
      req_from_x <= fx; req_from_y <= fy; req_from_z <= fz;
      req_to_x <= tx; req_to_y <= ty; req_to_z <= tz;
      req_valid <= 1;
      do @(posedge clock); while (req_stall);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   initial begin
      logic [IN_W-1:0] fx, fy, fz;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_pair(0, 0, 0, 0, 0, 0);
      send_pair(24'h123456, 24'h800000, 24'h7FFFFF, 24'h123456, 24'h800000, 24'h7FFFFF);
      send_pair(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
      send_pair(24'h800000, 0, 0, 24'h7FFFFF, 0, 0);
      send_pair(0, 24'h7FFFFF, 0, 0, 24'h800000, 0);
      send_pair(0, 0, 0, 0, 0, 1);
      send_pair(0, 0, 0, 24'hFFFFFF, 0, 0);
      send_pair(0, 0, 0, 1, 1, 1);
      send_pair(0, 0, 0, 24'hFFFFFF, 1, 24'hFFFFFF);
      send_pair(0, 0, 0, 3, 4, 0);
      send_pair(0, 0, 0, 24'h7FFFFF, 1, 0);
      send_pair(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
      req_valid <= 0;
      // hold off until the pipeline has drained
      while (pending != 0) @(posedge clock);
      for (int i = 0; i < 1800; i++) begin
         if (i == 1500) quiet = 1;
         fx = IN_W'({$urandom}); fy = IN_W'({$urandom}); fz = IN_W'({$urandom});
         send_pair(fx, fy, fz, pick_coord(fx), pick_coord(fy), pick_coord(fz));
      end
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

// File: files.f
rtl/core/ud3_pkg.sv
rtl/core/ud3_prep.sv
rtl/core/ud3_step.sv
rtl/core/unit_direction_3d.sv
bench/unit_direction_3d_checker.sv
bench/tb_unit_direction_3d.sv
